FILE: sv/apq_pkg.sv
package apq_pkg;

  localparam int DefCapacity = 64;
  localparam int DefMaxDrain = 16;
  localparam int ResultLimit = 16;

  localparam logic [15:0] PRIO_MAX  = 16'hFFFF;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;
  localparam logic [15:0] TICK_INIT = 16'd1;

  localparam logic [4:0] DRAIN_RESET = 5'd1;
  localparam logic [6:0] CAP_RESET   = 7'd64;

  localparam logic REG_DRAIN = 1'b0;
  localparam logic REG_CAP   = 1'b1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] prio;
    logic [7:0]  inc;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_POP,
    OP_AGE,
    OP_SORT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   ins_entry;
  } cell_cmd_t;

  function automatic logic [15:0] sat_add(logic [15:0] p, logic [7:0] inc);
    logic [16:0] s;
    s = {1'b0, p} + {9'b0, inc};
    return s[16] ? PRIO_MAX : s[15:0];
  endfunction

endpackage

FILE: sv/apq_cell.sv
module apq_cell #(
  parameter int RW = 6
) (
  input  logic               clk_i,
  input  apq_pkg::cell_cmd_t cmd_i,
  input  logic [RW-1:0]      ins_rank_i,
  input  logic [RW-1:0]      gone_rank_i,
  input  logic               live_i,
  input  logic               right_live_i,
  input  logic               pair_left_i,
  input  apq_pkg::entry_t    left_entry_i,
  input  logic [RW-1:0]      left_rank_i,
  input  logic               left_before_i,
  input  logic               left_swap_i,
  input  apq_pkg::entry_t    right_entry_i,
  input  logic [RW-1:0]      right_rank_i,
  output apq_pkg::entry_t    entry_o,
  output logic [RW-1:0]      rank_o,
  output logic               before_o,
  output logic               swap_o
);
  import apq_pkg::*;

  entry_t        entry_q, entry_d;
  logic [RW-1:0] rank_q, rank_d;
  logic          right_wins;

  assign right_wins = (right_entry_i.prio > entry_q.prio) ||
                      ((right_entry_i.prio == entry_q.prio) && (right_rank_i < rank_q));
  assign before_o   = !live_i || (cmd_i.ins_entry.prio > entry_q.prio);
  assign swap_o     = (cmd_i.op == OP_SORT) && pair_left_i && right_live_i && right_wins;

  always_comb begin
    entry_d = entry_q;
    rank_d  = rank_q;
    unique case (cmd_i.op)
      OP_NOP: begin
      end
      OP_INSERT: begin
        if (left_before_i) begin
          entry_d = left_entry_i;
          rank_d  = left_rank_i;
        end else if (before_o) begin
          entry_d = cmd_i.ins_entry;
          rank_d  = ins_rank_i;
        end
      end
      OP_POP: begin
        entry_d = right_entry_i;
        rank_d  = right_rank_i - {{(RW-1){1'b0}}, (right_rank_i > gone_rank_i)};
      end
      OP_AGE: begin
        if (live_i) begin
          entry_d.prio = sat_add(entry_q.prio, entry_q.inc);
        end
      end
      OP_SORT: begin
        if (swap_o) begin
          entry_d = right_entry_i;
          rank_d  = right_rank_i;
        end else if (left_swap_i) begin
          entry_d = left_entry_i;
          rank_d  = left_rank_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rank_q  <= rank_d;
  end

  assign entry_o = entry_q;
  assign rank_o  = rank_q;

endmodule

FILE: sv/apq_array.sv
module apq_array #(
  parameter int CAPACITY = apq_pkg::DefCapacity,
  parameter int RW       = $clog2(CAPACITY),
  parameter int OW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  apq_pkg::cell_cmd_t cmd_i,
  input  logic [RW-1:0]      ins_rank_i,
  input  logic [OW-1:0]      occ_i,
  input  logic               phase_i,
  output apq_pkg::entry_t    head_entry_o,
  output logic               any_swap_o
);
  import apq_pkg::*;

  entry_t              ent   [CAPACITY];
  logic [RW-1:0]       rank  [CAPACITY];
  logic [CAPACITY-1:0] live;
  logic [CAPACITY-1:0] ahead;
  logic [CAPACITY-1:0] swap;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t        left_ent, right_ent;
    logic [RW-1:0] left_rank, right_rank;
    logic          left_before, left_swap, right_live, pair_left;

    assign live[i] = (occ_i > OW'(i));

    if (i == 0) begin : g_first
      assign left_ent    = ent[i];
      assign left_rank   = rank[i];
      assign left_before = 1'b0;
      assign left_swap   = 1'b0;
    end else begin : g_mid_l
      assign left_ent    = ent[i-1];
      assign left_rank   = rank[i-1];
      assign left_before = ahead[i-1];
      assign left_swap   = swap[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent  = ent[i];
      assign right_rank = rank[i];
      assign right_live = 1'b0;
      assign pair_left  = 1'b0;
    end else begin : g_mid_r
      assign right_ent  = ent[i+1];
      assign right_rank = rank[i+1];
      assign right_live = live[i+1];
      assign pair_left  = (phase_i == 1'(i % 2));
    end

    apq_cell #(
      .RW (RW)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd_i),
      .ins_rank_i    (ins_rank_i),
      .gone_rank_i   (rank[0]),
      .live_i        (live[i]),
      .right_live_i  (right_live),
      .pair_left_i   (pair_left),
      .left_entry_i  (left_ent),
      .left_rank_i   (left_rank),
      .left_before_i (left_before),
      .left_swap_i   (left_swap),
      .right_entry_i (right_ent),
      .right_rank_i  (right_rank),
      .entry_o       (ent[i]),
      .rank_o        (rank[i]),
      .before_o      (ahead[i]),
      .swap_o        (swap[i])
    );
  end

  assign head_entry_o = ent[0];
  assign any_swap_o   = |swap;

endmodule

FILE: sv/aging_priority_packet_queue_core.sv
// Aging priority packet queue.
// Input channel (in_valid_i/in_ready_o) takes insert and tick items; output
// channel (out_valid_o/out_ready_i) gives drained packets, one per item.
// Packets live in a chain of cells kept sorted by priority, then arrival.
// A full queue or an id of zero drops an insert silently.
// A tick drains up to min(drain_per_tick, MAX_DRAIN, 16) packets from the
// head cell, one per cycle while the output register is free, then ages
// every cell in the AGE state and then re-sorts the chain by odd-even
// exchange between neighbor cells, ending after two quiet phases in a row.
// A tick that drains nothing gives one marker item.
// The first item of a tick is registered in ST_DRAIN when output is free.
// The input is taken only when no tick is in progress; a stalled receiver
// holds the result register and pauses the drain.
// Reset empties the queue, sets the tick count to 1, drain_per_tick to 1 and
// capacity_limit to 64. Registers sit on an APB port at byte addresses 0 and 4.
module aging_priority_packet_queue_core #(
  parameter int CAPACITY  = apq_pkg::DefCapacity,
  parameter int MAX_DRAIN = apq_pkg::DefMaxDrain
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] packet_id_i,
  input  logic [15:0] priority_req_i,
  input  logic [7:0]  increment_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_priority_o,
  output logic [7:0]  out_increment_o,
  output logic [15:0] tick_number_o,
  output logic        last_o
);
  import apq_pkg::*;

  localparam int RW        = $clog2(CAPACITY);
  localparam int OW        = $clog2(CAPACITY + 1);
  localparam int CW        = (OW > 7) ? OW : 7;
  localparam int DrainCap  = (MAX_DRAIN < ResultLimit) ? MAX_DRAIN : ResultLimit;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_AGE,
    ST_SORT
  } state_e;

  state_e        state_q;
  logic [4:0]    drain_q;
  logic [6:0]    cap_q;
  logic [OW-1:0] occ_q;
  logic [15:0]   tick_q;
  logic [15:0]   cur_tick_q;
  logic [15:0]   out_tick_q;
  logic [4:0]    cnt_q;
  logic          phase_q;
  logic          quiet_q;
  logic          out_valid_q;
  logic          valid_res_q;
  entry_t        out_entry_q;
  logic          last_q;

  cell_cmd_t     cmd;
  entry_t        head_entry;
  logic          any_swap;
  logic          in_acc;
  logic          cfg_wr;
  logic          out_free;
  logic          has_room;
  logic          do_pop;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_lim;
  logic [4:0]    drain_cnt;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_CAP) ? {25'b0, cap_q} : {27'b0, drain_q};

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign cap_ext   = CW'(cap_q);
  assign cap_lim   = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
  assign has_room  = (CW'(occ_q) < cap_lim);
  assign drain_cnt = (drain_q > 5'(DrainCap)) ? 5'(DrainCap) : drain_q;
  assign do_pop    = (state_q == ST_DRAIN) && out_free && (cnt_q != 5'd0) &&
                     (occ_q != '0);

  always_comb begin
    cmd.op             = OP_NOP;
    cmd.ins_entry.id   = packet_id_i;
    cmd.ins_entry.prio = priority_req_i;
    cmd.ins_entry.inc  = increment_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (func_i == FUNC_INSERT) && (packet_id_i != 16'd0) && has_room) begin
          cmd.op = OP_INSERT;
        end
      end
      ST_DRAIN: begin
        if (do_pop) begin
          cmd.op = OP_POP;
        end
      end
      ST_AGE:  cmd.op = OP_AGE;
      ST_SORT: cmd.op = OP_SORT;
      default: cmd.op = OP_NOP;
    endcase
  end

  apq_array #(
    .CAPACITY (CAPACITY),
    .RW       (RW),
    .OW       (OW)
  ) u_array (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .ins_rank_i   (occ_q[RW-1:0]),
    .occ_i        (occ_q),
    .phase_i      (phase_q),
    .head_entry_o (head_entry),
    .any_swap_o   (any_swap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drain_q     <= DRAIN_RESET;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      tick_q      <= TICK_INIT;
      cur_tick_q  <= TICK_INIT;
      out_tick_q  <= TICK_INIT;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      quiet_q     <= 1'b0;
      out_valid_q <= 1'b0;
      valid_res_q <= 1'b0;
      out_entry_q <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_CAP) begin
          cap_q <= pwdata[6:0];
        end else begin
          drain_q <= pwdata[4:0];
        end
      end

      if (out_valid_q && out_ready_i && (state_q != ST_DRAIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd.op == OP_INSERT) begin
            occ_q <= occ_q + OW'(1);
          end
          if (in_acc && (func_i == FUNC_TICK)) begin
            cur_tick_q <= tick_q;
            tick_q     <= (tick_q == TICK_MAX) ? TICK_INIT : tick_q + 16'd1;
            cnt_q      <= drain_cnt;
            state_q    <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_tick_q  <= cur_tick_q;
            if (do_pop) begin
              valid_res_q <= 1'b1;
              out_entry_q <= head_entry;
              last_q      <= (cnt_q == 5'd1) || (occ_q == OW'(1));
              occ_q       <= occ_q - OW'(1);
              cnt_q       <= cnt_q - 5'd1;
              if ((cnt_q == 5'd1) || (occ_q == OW'(1))) begin
                state_q <= ST_AGE;
              end
            end else begin
              valid_res_q <= 1'b0;
              out_entry_q <= '0;
              last_q      <= 1'b1;
              state_q     <= ST_AGE;
            end
          end
        end
        ST_AGE: begin
          phase_q <= 1'b0;
          quiet_q <= 1'b0;
          state_q <= ST_SORT;
        end
        ST_SORT: begin
          phase_q <= !phase_q;
          quiet_q <= !any_swap;
          if (!any_swap && quiet_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = valid_res_q;
  assign out_id_o        = out_entry_q.id;
  assign out_priority_o  = out_entry_q.prio;
  assign out_increment_o = out_entry_q.inc;
  assign tick_number_o   = out_tick_q;
  assign last_o          = last_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_pop_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (occ_q == $past(occ_q) - OW'(1)))
    else $error("drain did not remove one packet");

  a_marker_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !valid_res_q) |-> last_q)
    else $error("empty-tick marker not marked last");

  a_sort_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT && any_swap) |=> (state_q == ST_SORT))
    else $error("sort ended while cells still exchanged");

  a_tick_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q != 16'd0)
    else $error("tick counter reached zero");

endmodule

FILE: verif/apq_drain_checker.sv
module apq_drain_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               func_i,
  input  logic [15:0]        packet_id_i,
  input  logic [15:0]        priority_req_i,
  input  logic [7:0]         increment_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               valid_res_i,
  input  logic [15:0]        out_id_i,
  input  logic [15:0]        out_priority_i,
  input  logic [7:0]         out_increment_i,
  input  logic [15:0]        tick_number_i,
  input  logic               last_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import apq_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [15:0] prio;
    logic [7:0]  inc;
    logic [15:0] tick;
    logic        last;
  } drain_item_t;

  entry_t      held_entry [DefCapacity];
  logic [15:0] held_rank  [DefCapacity];
  int unsigned held_count;
  logic [15:0] next_tick;
  logic [4:0]  drain_reg;
  logic [6:0]  cap_reg;
  drain_item_t drain_expect_q[$];

  function automatic int unsigned best_slot();
    int unsigned best;
    int unsigned i;
    best = 0;
    for (i = 1; i < held_count; i++) begin
      if (held_entry[i].prio > held_entry[best].prio ||
          (held_entry[i].prio == held_entry[best].prio &&
           held_rank[i] < held_rank[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void retire_slot(int unsigned s);
    logic [15:0] gone;
    int unsigned i;
    gone = held_rank[s];
    held_count = held_count - 1;
    held_entry[s] = held_entry[held_count];
    held_rank[s] = held_rank[held_count];
    for (i = 0; i < held_count; i++) begin
      if (held_rank[i] > gone) begin
        held_rank[i] = held_rank[i] - 16'd1;
      end
    end
  endfunction

  function automatic void predict_insert(logic [15:0] id, logic [15:0] prio, logic [7:0] inc);
    int unsigned room;
    room = (cap_reg < DefCapacity) ? cap_reg : DefCapacity;
    if (id != 16'd0 && held_count < room) begin
      held_entry[held_count] = {id, prio, inc};
      held_rank[held_count] = 16'(held_count);
      held_count = held_count + 1;
    end
  endfunction

  function automatic void predict_tick();
    drain_item_t rec;
    logic [15:0] this_tick;
    int unsigned quota;
    int unsigned n;
    int unsigned s;
    int unsigned i;
    logic [16:0] sum;
    this_tick = next_tick;
    next_tick = (next_tick == TICK_MAX) ? TICK_INIT : next_tick + 16'd1;
    quota = drain_reg;
    if (quota > DefMaxDrain) quota = DefMaxDrain;
    if (quota > ResultLimit) quota = ResultLimit;
    n = 0;
    while (n < quota && held_count > 0) begin
      s = best_slot();
      rec.valid = 1'b1;
      rec.id = held_entry[s].id;
      rec.prio = held_entry[s].prio;
      rec.inc = held_entry[s].inc;
      rec.tick = this_tick;
      retire_slot(s);
      n = n + 1;
      rec.last = (n == quota) || (held_count == 0);
      drain_expect_q.push_back(rec);
    end
    if (n == 0) begin
      rec.valid = 1'b0;
      rec.id = 16'd0;
      rec.prio = 16'd0;
      rec.inc = 8'd0;
      rec.tick = this_tick;
      rec.last = 1'b1;
      drain_expect_q.push_back(rec);
    end
    for (i = 0; i < held_count; i++) begin
      sum = {1'b0, held_entry[i].prio} + {9'd0, held_entry[i].inc};
      held_entry[i].prio = sum[16] ? 16'hFFFF : sum[15:0];
    end
  endfunction

  function automatic int unsigned field_mismatch(string name, logic [15:0] want,
                                                 logic [15:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drain_item_t want;
    if (!rst_ni) begin
      held_count = 0;
      next_tick = TICK_INIT;
      drain_reg = DRAIN_RESET;
      cap_reg = CAP_RESET;
      drain_expect_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (drain_expect_q.size() == 0) begin
          $error("unexpected item id %0h tick %0h", out_id_i, tick_number_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = drain_expect_q.pop_front();
          fail_count_o = fail_count_o
            + field_mismatch("valid_res", 16'(want.valid), 16'(valid_res_i))
            + field_mismatch("out_id", want.id, out_id_i)
            + field_mismatch("out_priority", want.prio, out_priority_i)
            + field_mismatch("out_increment", 16'(want.inc), 16'(out_increment_i))
            + field_mismatch("tick_number", want.tick, tick_number_i)
            + field_mismatch("last", 16'(want.last), 16'(last_i));
        end
      end
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_DRAIN) begin
          drain_reg = pwdata[4:0];
        end else begin
          cap_reg = pwdata[6:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_TICK) begin
          predict_tick();
        end else begin
          predict_insert(packet_id_i, priority_req_i, increment_i);
        end
      end
    end
    pending_o = drain_expect_q.size();
  end

endmodule

FILE: verif/tb_aging_priority_packet_queue_core.sv
module tb_aging_priority_packet_queue_core;
  import apq_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int ResetCycles   = 7;
  localparam int SettleCycles  = 100;
  localparam int HoldOffCycles = 400;
  localparam int IdleLimit     = 3000;
  localparam int PhaseItems    = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [15:0] packet_id_i;
  logic [15:0] priority_req_i;
  logic [7:0]  increment_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        valid_res_o;
  logic [15:0] out_id_o;
  logic [15:0] out_priority_o;
  logic [7:0]  out_increment_o;
  logic [15:0] tick_number_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          calm;
  bit          hold_req;

  int unsigned drain_plan [6] = '{1, 16, 0, 31, 3, 7};
  int unsigned cap_plan   [6] = '{64, 127, 5, 1, 0, 2};
  int unsigned tick_plan  [6] = '{25, 10, 30, 25, 20, 25};

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  aging_priority_packet_queue_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .packet_id_i     (packet_id_i),
    .priority_req_i  (priority_req_i),
    .increment_i     (increment_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_res_o     (valid_res_o),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .out_increment_o (out_increment_o),
    .tick_number_o   (tick_number_o),
    .last_o          (last_o)
  );

  apq_drain_checker drain_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .packet_id_i     (packet_id_i),
    .priority_req_i  (priority_req_i),
    .increment_i     (increment_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_res_i     (valid_res_o),
    .out_id_i        (out_id_o),
    .out_priority_i  (out_priority_o),
    .out_increment_i (out_increment_o),
    .tick_number_i   (tick_number_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic f, input logic [15:0] id, input logic [15:0] prio,
                           input logic [7:0] inc);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    packet_id_i <= id;
    priority_req_i <= prio;
    increment_i <= inc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned tick_pct);
    logic [15:0] id;
    logic [15:0] prio;
    logic [7:0]  inc;
    id = 16'($urandom_range(1, 16'hFFFF));
    if ($urandom_range(0, 31) == 0) id = 16'd0;
    else if ($urandom_range(0, 31) == 0) id = 16'hFFFF;
    case ($urandom_range(0, 4))
      0: prio = 16'd0;
      1: prio = 16'hFFFF;
      2: prio = 16'($urandom_range(0, 7));
      3: prio = 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: prio = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: inc = 8'd0;
      1: inc = 8'hFF;
      default: inc = 8'($urandom);
    endcase
    if ($urandom_range(0, 99) < tick_pct) begin
      push_item(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      push_item(FUNC_INSERT, id, prio, inc);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned drain, input int unsigned cap);
    settle();
    write_reg(REG_DRAIN, (32'($urandom) & ~32'h1F) | 32'(drain));
    write_reg(REG_CAP, (32'($urandom) & ~32'h7F) | 32'(cap));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_INSERT;
    packet_id_i = '0;
    priority_req_i = '0;
    increment_i = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    push_item(FUNC_INSERT, 16'h0001, 16'h0000, 8'h00);
    push_item(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_item(FUNC_INSERT, 16'h0000, 16'h1234, 8'h01);
    push_item(FUNC_INSERT, 16'h000A, 16'h0100, 8'h10);
    push_item(FUNC_INSERT, 16'h000B, 16'h0100, 8'h10);
    push_item(FUNC_INSERT, 16'h000C, 16'hFFF8, 8'h20);
    push_item(FUNC_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    set_config(16, 64);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    set_config(0, 64);
    push_item(FUNC_INSERT, 16'h0005, 16'h0007, 8'h03);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    set_config(31, 2);
    push_item(FUNC_INSERT, 16'h0006, 16'h0007, 8'h03);
    push_item(FUNC_INSERT, 16'h0007, 16'hFFFF, 8'h00);
    push_item(FUNC_INSERT, 16'h0008, 16'hFFFF, 8'h00);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    set_config(1, 0);
    push_item(FUNC_INSERT, 16'h0009, 16'h0001, 8'h01);
    push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        set_config($urandom_range(0, 31), $urandom_range(0, 127));
      end else begin
        set_config(drain_plan[p], cap_plan[p]);
      end
      repeat (PhaseItems) push_random(tick_plan[p]);
    end

    // fill the queue while the receiver holds off, then stall on ticks
    set_config(16, 64);
    hold_req = 1'b1;
    repeat (70) push_random(0);
    repeat (4) push_item(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    repeat (PhaseItems) push_random(25);

    set_config(16, 64);
    calm = 1'b1;
    repeat (5) push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);
    push_item(FUNC_INSERT, 16'h1111, 16'h0010, 8'h01);
    push_item(FUNC_INSERT, 16'h2222, 16'h0020, 8'h02);
    push_item(FUNC_INSERT, 16'h3333, 16'h0010, 8'h03);
    repeat (8) push_item(FUNC_TICK, 16'd0, 16'd0, 8'd0);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
